### sv/pal_pkg.sv
// Package for the lowest-free-first page allocator.
// Holds the sizing constants, command and status codes and the beat types.
// No dependencies.
`default_nettype none

package pal_pkg;

   localparam int MAX_PAGES = 1024;
   localparam int PAGE_W    = 10;
   localparam int COUNT_W   = $clog2(MAX_PAGES + 1);
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WORD_CNT  = MAX_PAGES / WORD_BITS;
   localparam int WIDX_W    = $clog2(WORD_CNT);

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_DEALLOC = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_READ    = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

   typedef struct packed {
      command_type         command;
      logic [PAGE_W-1:0]   page_number;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   given_page;
      logic [COUNT_W-1:0]  pages_in_use;
   } rsp_type;

endpackage

`default_nettype wire

### sv/page_allocator_lowest_free.sv
// Top level of the lowest-free-first page allocator and bounds checker.
// Uses pal_pkg for constants, codes and beat types.
`default_nettype none

// The block takes one request beat at a time and answers each with one
// response beat carrying the status, the page handed out and the page count
// afterwards. The free map lives in a 32 x 32-bit memory whose words carry a
// valid flag cleared by reset, so no clearing pass is needed. Read and write
// requests go from idle straight to the done state; deallocate first passes
// through a check state unless it is ignored at once. Allocate scans the
// memory one word per cycle through its single read port, stopping at the
// word holding the lowest free page or after the last word. A waiting response
// beat does not hold off the next request beat, but that request then waits
// in its done state until the response register is free.
module page_allocator_lowest_free
   import pal_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DCHECK = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [WIDX_W-1:0]        word_idx_ff, word_idx_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PAGE_W-1:0]        page_ff, page_in;
   rsp_type                  res_ff, res_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [WORD_BITS-1:0]     mem [WORD_CNT];
   logic [WORD_CNT-1:0]      word_valid_ff;
   logic [WORD_BITS-1:0]     rd_data_ff;
   logic                     rd_valid_ff;
   logic [WIDX_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [WIDX_W-1:0]        wr_addr;
   logic [WORD_BITS-1:0]     wr_data;

   logic [WORD_BITS-1:0]     word;
   logic [BIT_W-1:0]         low_bit;
   logic                     req_take;
   logic [COUNT_W-1:0]       req_page_ext;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_page_ext = COUNT_W'(req_data.page_number);
   assign word         = rd_valid_ff ? rd_data_ff : '0;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      word_idx_in  = word_idx_ff;
      count_in     = count_ff;
      page_in      = page_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = word_idx_ff;
      wr_data      = '0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_data.page_number[PAGE_W-1:BIT_W];
            if (req_take) begin
               page_in             = req_data.page_number;
               res_in.status       = ST_OK;
               res_in.given_page   = '0;
               res_in.pages_in_use = count_ff;
               state_in            = S_DONE;
               unique case (req_data.command)
                  CMD_ALLOC: begin
                     rd_addr     = '0;
                     word_idx_in = '0;
                     state_in    = S_SCAN;
                  end
                  CMD_DEALLOC: begin
                     if (req_data.page_number == '0 || req_page_ext >= count_ff) begin
                        res_in.status = ST_IGNORED;
                     end else begin
                        state_in = S_DCHECK;
                     end
                  end
                  CMD_WRITE: begin
                     if (req_page_ext > count_ff) begin
                        res_in.status = ST_INVALID;
                     end else if (req_page_ext == count_ff) begin
                        if (count_ff < COUNT_W'(MAX_PAGES)) begin
                           count_in            = count_ff + COUNT_W'(1);
                           res_in.pages_in_use = count_ff + COUNT_W'(1);
                        end else begin
                           res_in.status = ST_FULL;
                        end
                     end
                  end
                  default: begin
                     if (req_page_ext >= count_ff) begin
                        res_in.status = ST_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr = word_idx_ff + WIDX_W'(1);
            if (word != '0) begin
               wr_en             = 1'b1;
               wr_addr           = word_idx_ff;
               wr_data           = word & ~(WORD_BITS'(1) << low_bit);
               res_in.given_page = {word_idx_ff, low_bit};
               state_in          = S_DONE;
            end else if (word_idx_ff == WIDX_W'(WORD_CNT - 1)) begin
               if (count_ff < COUNT_W'(MAX_PAGES)) begin
                  res_in.given_page   = count_ff[PAGE_W-1:0];
                  count_in            = count_ff + COUNT_W'(1);
                  res_in.pages_in_use = count_ff + COUNT_W'(1);
               end else begin
                  res_in.status = ST_FULL;
               end
               state_in = S_DONE;
            end else begin
               word_idx_in = word_idx_ff + WIDX_W'(1);
            end
         end
         S_DCHECK: begin
            if (word[page_ff[BIT_W-1:0]]) begin
               res_in.status = ST_IGNORED;
            end else begin
               wr_en   = 1'b1;
               wr_addr = page_ff[PAGE_W-1:BIT_W];
               wr_data = word | (WORD_BITS'(1) << page_ff[BIT_W-1:0]);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= COUNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         word_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            word_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_idx_ff <= word_idx_in;
      page_ff     <= page_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= word_valid_ff[rd_addr];
   end

   // A request beat is never followed by another in the next cycle.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in progress");

   // The page count stays within one and the maximum.
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= COUNT_W'(MAX_PAGES))
      else $error("page count out of range");

   // The page count never shrinks outside reset.
   a_count_grows : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("page count decreased");

endmodule

`default_nettype wire
